>>> src/gsac_pkg.sv
// gsac_pkg: shared types and constants of the glyph set-associative tag store
// request and result field widths, operation codes, default geometry
// no dependencies
`default_nettype none

package gsac_pkg;

  localparam int CODE_W = 21;
  localparam int FONT_W = 8;
  localparam int SET_OUT_W = 8;
  localparam int WAY_OUT_W = 2;

  localparam int FONT_SETS_DEF = 4;
  localparam int CODE_SETS_DEF = 64;
  localparam int WAYS_DEF = 4;

  // reciprocal for the code-point remainder
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W = 30;
  localparam int PROD_W = CODE_W + RECIP_W;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ALLOC  = 1'b1
  } op_t;

endpackage

`default_nettype wire

>>> src/gsac_ram.sv
// gsac_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/glyph_set_assoc_cache_unit.sv
// glyph_set_assoc_cache_unit: glyph cache tag store, one wide tag row per set
// depends on gsac_pkg and gsac_ram (tag row memory and round-robin pointer memory)
// an accepted request steps through MUL1, MUL2, MUL3, READ and EVAL, then its result is loaded into the output register
// one request at a time: in_stall is high until it has passed set remainder, ram read and compare/write back
// a pending result may wait in the output register while the next request is accepted
// reset: clearing pass writes all FONT_SETS*CODE_SETS rows (256 by default), in_stall held high
`default_nettype none

module glyph_set_assoc_cache_unit #(
  parameter int FONT_SETS = gsac_pkg::FONT_SETS_DEF,
  parameter int CODE_SETS = gsac_pkg::CODE_SETS_DEF,
  parameter int WAYS = gsac_pkg::WAYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_operation,
  input  wire logic [gsac_pkg::CODE_W-1:0]   in_code_point,
  input  wire logic [gsac_pkg::FONT_W-1:0]   in_font_ident,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [gsac_pkg::SET_OUT_W-1:0]     out_set_index,
  output logic [gsac_pkg::WAY_OUT_W-1:0]     out_way_index
);

  localparam int SET_COUNT = FONT_SETS * CODE_SETS;
  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W = gsac_pkg::CODE_W + gsac_pkg::FONT_W;
  localparam int ROW_W = WAYS * TAG_W;
  localparam longint unsigned RECIP =
    (64'd1 << gsac_pkg::RECIP_SHIFT) / CODE_SETS;
  localparam int QC_W = gsac_pkg::CODE_W + 9;
  localparam int RD_W = gsac_pkg::CODE_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_MUL3  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  logic                           op_r;
  logic [gsac_pkg::CODE_W-1:0]    code_r;
  logic [gsac_pkg::FONT_W-1:0]    font_r;
  logic [gsac_pkg::FONT_W-1:0]    fmod_r;
  logic [gsac_pkg::PROD_W-1:0]    prod_r;
  logic [QC_W-1:0]                qc_r;
  logic [SET_W-1:0]               fbase_r;
  logic [SET_W-1:0]               set_r;
  logic [SET_W-1:0]               set_out_r;
  logic                           hit_r;
  logic [PTR_W-1:0]               way_r;

  logic [gsac_pkg::FONT_W-1:0] font_mod_tbl [256];

  logic in_fire;
  logic eval_fire;
  logic [gsac_pkg::CODE_W-1:0] quot;
  logic [16:0] fbase_full;
  logic [RD_W-1:0] rem_full;
  logic [8:0] rem_code;
  logic [SET_W-1:0] set_nxt;

  logic             ram_rd_en;
  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] row_rd, row_wr;
  logic [PTR_W-1:0] ptr_rd, ptr_wr;

  logic             look_hit;
  logic [PTR_W-1:0] look_way;
  logic [PTR_W-1:0] victim;
  logic [PTR_W:0]   victim_inc;

  for (genvar i = 0; i < 256; i++) begin : g_font_mod
    assign font_mod_tbl[i] = gsac_pkg::FONT_W'(i % FONT_SETS);
  end

  assign in_fire   = (state_r == S_IDLE) && in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign eval_fire = (state_r == S_EVAL) && (!out_valid_r || !out_stall);

  // code point remainder by reciprocal with one correction step
  assign quot       = prod_r[gsac_pkg::RECIP_SHIFT +: gsac_pkg::CODE_W];
  assign fbase_full = 17'(fmod_r) * 17'(CODE_SETS);

  always_comb begin
    rem_full = {1'b0, code_r} - qc_r[RD_W-1:0];
    if (rem_full >= RD_W'(CODE_SETS)) begin
      rem_full = rem_full - RD_W'(CODE_SETS);
    end
    rem_code = rem_full[8:0];
    set_nxt  = SET_W'(17'(fbase_r) + 17'(rem_code));
  end

  // lookup compare, lowest matching way wins
  always_comb begin
    look_hit = 1'b0;
    look_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w*TAG_W +: TAG_W] == {code_r, font_r}) begin
        look_hit = 1'b1;
        look_way = PTR_W'(w);
      end
    end
  end

  always_comb begin
    victim = (32'(ptr_rd) >= WAYS) ? '0 : ptr_rd;
    victim_inc = {1'b0, victim} + 1'b1;
    row_wr = row_rd;
    row_wr[victim*TAG_W +: TAG_W] = {code_r, font_r};
    ptr_wr = (32'(victim_inc) >= WAYS) ? '0 : victim_inc[PTR_W-1:0];
    if (state_r == S_CLEAR) begin
      row_wr = '0;
      ptr_wr = '0;
    end
  end

  assign ram_rd_en   = (state_r == S_READ);
  assign ram_wr_en   = (state_r == S_CLEAR) ||
                       (eval_fire && (op_r == gsac_pkg::OP_ALLOC));
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_cnt_r : set_r;

  gsac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (row_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (set_r),
    .rd_data (row_rd)
  );

  gsac_ram #(
    .WIDTH (PTR_W),
    .DEPTH (SET_COUNT),
    .AW    (SET_W)
  ) u_ptr_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ptr_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (set_r),
    .rd_data (ptr_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_READ;
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (eval_fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_operation;
      code_r <= in_code_point;
      font_r <= in_font_ident;
      fmod_r <= font_mod_tbl[in_font_ident];
    end
    if (state_r == S_MUL1) begin
      prod_r <= gsac_pkg::PROD_W'(code_r) *
                gsac_pkg::PROD_W'(gsac_pkg::RECIP_W'(RECIP));
    end
    if (state_r == S_MUL2) begin
      qc_r    <= QC_W'(quot) * QC_W'(CODE_SETS);
      fbase_r <= fbase_full[SET_W-1:0];
    end
    if (state_r == S_MUL3) begin
      set_r <= set_nxt;
    end
    if (eval_fire) begin
      set_out_r <= set_r;
      if (op_r == gsac_pkg::OP_ALLOC) begin
        hit_r <= 1'b0;
        way_r <= victim;
      end else begin
        hit_r <= look_hit;
        way_r <= look_way;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_set_index = gsac_pkg::SET_OUT_W'(set_out_r);
  assign out_way_index = gsac_pkg::WAY_OUT_W'(way_r);

  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (32'(set_r) < SET_COUNT))
    else $error("set index out of range");

  a_alloc_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (eval_fire && (op_r == gsac_pkg::OP_ALLOC)) |=> (out_valid && !out_hit))
    else $error("allocate reported a hit");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !ram_wr_en)
    else $error("tag write during row read");

  a_result_follows_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eval_fire |=> (out_valid && (state_r == S_IDLE)))
    else $error("result not loaded after compare");

endmodule

`default_nettype wire

>>> dv/glyph_set_assoc_cache_unit_tb.sv
`timescale 1ns / 1ps
// glyph_set_assoc_cache_unit_tb: self-checking bench for the glyph cache tag store
// keeps its own tag and round-robin pointer arrays, predicts hit, set and way per request
// depends on gsac_pkg and glyph_set_assoc_cache_unit
module glyph_set_assoc_cache_unit_tb;

  localparam int FONT_SETS = gsac_pkg::FONT_SETS_DEF;
  localparam int CODE_SETS = gsac_pkg::CODE_SETS_DEF;
  localparam int WAYS = gsac_pkg::WAYS_DEF;
  localparam int CODE_W = gsac_pkg::CODE_W;
  localparam int FONT_W = gsac_pkg::FONT_W;
  localparam int SET_OUT_W = gsac_pkg::SET_OUT_W;
  localparam int WAY_OUT_W = gsac_pkg::WAY_OUT_W;
  localparam int SET_COUNT = FONT_SETS * CODE_SETS;
  localparam int CODE_MAX = 1114111;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 50000;

  typedef struct packed {
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [WAY_OUT_W-1:0] way_index;
  } glyph_res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [FONT_W-1:0] font;
  } glyph_key_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = 1'b0;
  logic [CODE_W-1:0]    in_code_point = '0;
  logic [FONT_W-1:0]    in_font_ident = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic [SET_OUT_W-1:0] out_set_index;
  logic [WAY_OUT_W-1:0] out_way_index;

  logic [CODE_W-1:0] cache_tag_code [SET_COUNT][WAYS];
  logic [FONT_W-1:0] cache_tag_font [SET_COUNT][WAYS];
  int                cache_victim [SET_COUNT];

  glyph_res_t pending_results [$];
  glyph_key_t recent_keys [$];
  glyph_res_t seen_res;
  glyph_res_t want_res;

  int  fail_count = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;

  glyph_set_assoc_cache_unit #(
    .FONT_SETS(FONT_SETS),
    .CODE_SETS(CODE_SETS),
    .WAYS(WAYS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_code_point(in_code_point),
    .in_font_ident(in_font_ident),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_set_index(out_set_index),
    .out_way_index(out_way_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("glyph_set_assoc_cache_unit_tb failed");
    $finish;
  end

  function automatic glyph_res_t predict_access(gsac_pkg::op_t op, logic [CODE_W-1:0] code,
                                                logic [FONT_W-1:0] font);
    glyph_res_t res;
    int set;
    int way;
    set = (int'(font) % FONT_SETS) * CODE_SETS + (int'(code) % CODE_SETS);
    res.hit = 1'b0;
    way = 0;
    if (op == gsac_pkg::OP_LOOKUP) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (cache_tag_code[set][w] == code && cache_tag_font[set][w] == font) begin
          res.hit = 1'b1;
          way = w;
        end
      end
    end else begin
      way = cache_victim[set];
      cache_tag_code[set][way] = code;
      cache_tag_font[set][way] = font;
      cache_victim[set] = (way + 1 >= WAYS) ? 0 : way + 1;
    end
    res.set_index = set[SET_OUT_W-1:0];
    res.way_index = way[WAY_OUT_W-1:0];
    return res;
  endfunction

  task automatic send_req(gsac_pkg::op_t op, logic [CODE_W-1:0] code,
                          logic [FONT_W-1:0] font);
    in_valid <= 1'b1;
    in_operation <= op;
    in_code_point <= code;
    in_font_ident <= font;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_results.push_back(predict_access(op, code, font));
    if (op == gsac_pkg::OP_ALLOC) begin
      recent_keys.push_back(glyph_key_t'{code, font});
      if (recent_keys.size() > 64) recent_keys.pop_front();
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hot keys crowd a handful of sets so victims rotate and evict
  task automatic gen_key(bit hot, output logic [CODE_W-1:0] code,
                         output logic [FONT_W-1:0] font);
    int hi;
    hi = $urandom_range(CODE_MAX >> 6);
    if (hot) begin
      code = CODE_W'((hi << 6) | $urandom_range(3));
      font = FONT_W'(($urandom_range(63) << 2) | $urandom_range(1));
    end else begin
      code = CODE_W'($urandom_range(CODE_MAX));
      font = FONT_W'($urandom_range(255));
    end
  endtask

  task automatic send_random_req();
    logic [CODE_W-1:0] code;
    logic [FONT_W-1:0] font;
    glyph_key_t key;
    int pick;
    pick = $urandom_range(99);
    gen_key(1'($urandom_range(1)), code, font);
    if (pick < 35) begin
      send_req(gsac_pkg::OP_ALLOC, code, font);
    end else if (pick < 80 && recent_keys.size() > 0) begin
      key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      // same set, different font tag now and then
      if ($urandom_range(9) == 0) key.font = key.font ^ FONT_W'(FONT_SETS);
      send_req(gsac_pkg::OP_LOOKUP, key.code, key.font);
    end else begin
      send_req(gsac_pkg::OP_LOOKUP, code, font);
    end
  endtask

  task automatic test_reset_contents();
    send_req(gsac_pkg::OP_LOOKUP, 21'd0, 8'd0);
    send_req(gsac_pkg::OP_LOOKUP, 21'd64, 8'd0);
    send_req(gsac_pkg::OP_LOOKUP, 21'd0, 8'd4);
    send_req(gsac_pkg::OP_LOOKUP, 21'(CODE_MAX), 8'hff);
  endtask

  task automatic test_field_extremes();
    send_req(gsac_pkg::OP_ALLOC, 21'(CODE_MAX), 8'hff);
    send_req(gsac_pkg::OP_LOOKUP, 21'(CODE_MAX), 8'hff);
    send_req(gsac_pkg::OP_ALLOC, 21'd0, 8'd0);
    send_req(gsac_pkg::OP_LOOKUP, 21'd0, 8'd0);
  endtask

  task automatic test_duplicate_tags();
    send_req(gsac_pkg::OP_ALLOC, 21'd10, 8'd2);
    send_req(gsac_pkg::OP_ALLOC, 21'd10, 8'd2);
    send_req(gsac_pkg::OP_LOOKUP, 21'd10, 8'd2);
  endtask

  task automatic test_victim_wrap();
    for (int k = 0; k <= WAYS; k++)
      send_req(gsac_pkg::OP_ALLOC, 21'(k * CODE_SETS + 5), 8'd1);
    send_req(gsac_pkg::OP_LOOKUP, 21'd5, 8'd1);
    send_req(gsac_pkg::OP_LOOKUP, 21'(CODE_SETS + 5), 8'd1);
    send_req(gsac_pkg::OP_LOOKUP, 21'(WAYS * CODE_SETS + 5), 8'd1);
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) send_random_req();
  endtask

  task automatic test_backpressure();
    hold_go <= ~hold_go;
    for (int i = 0; i < 24; i++) send_random_req();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_res = '{out_hit, out_set_index, out_way_index};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: hit=%0d set=%0d way=%0d",
                   seen_res.hit, seen_res.set_index, seen_res.way_index);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res !== want_res) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected hit=%0d set=%0d way=%0d, got hit=%0d set=%0d way=%0d",
                     want_res.hit, want_res.set_index, want_res.way_index,
                     seen_res.hit, seen_res.set_index, seen_res.way_index);
        end
      end
    end
  end

  initial begin
    int waited;
    for (int s = 0; s < SET_COUNT; s++) begin
      cache_victim[s] = 0;
      for (int w = 0; w < WAYS; w++) begin
        cache_tag_code[s][w] = '0;
        cache_tag_font[s][w] = '0;
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 23;
    rcv_idle_pct = 72;
    test_reset_contents();
    test_field_extremes();
    test_duplicate_tags();
    test_victim_wrap();
    test_random_traffic(440);

    snd_idle_pct = 72;
    rcv_idle_pct = 23;
    test_random_traffic(440);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(440);

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("glyph_set_assoc_cache_unit_tb passed");
    end else begin
      $display("glyph_set_assoc_cache_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> glyph_set_assoc_cache_unit.f
src/gsac_pkg.sv
src/gsac_ram.sv
src/glyph_set_assoc_cache_unit.sv
dv/glyph_set_assoc_cache_unit_tb.sv
